/* design/adc_meter_display_driver_macros.svh */
// Assertion macros for the ADC meter display driver.
// Included by design files that carry concurrent checks; no other dependencies.
`ifndef ADC_METER_DISPLAY_DRIVER_MACROS_SVH
`define ADC_METER_DISPLAY_DRIVER_MACROS_SVH

`ifndef ASSERT_OFF
`define AMD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define AMD_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AMD_ASSERT(label, clk, rst, prop, msg)
`define AMD_ASSERT_NORST(label, clk, prop, msg)
`endif

`endif

/* design/admdd_pkg.sv */
// Types, constants and lookup tables for the ADC meter display driver.
// No dependencies; imported by adc_meter_display_driver.
package admdd_pkg;

   localparam int SAMPLE_W   = 10;
   localparam int REQ_DATA_W = 16;
   localparam int BAR_W      = 8;
   localparam int DIGEN_W    = 4;
   localparam int SEG_W      = 8;
   localparam int RSP_DATA_W = 40;
   localparam int POS_W      = 2;
   localparam int DIGIT_NUM  = 4;
   localparam int DIGIT_W    = 4;

   // input kinds
   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_TICK   = 1'b1;

   localparam logic [POS_W-1:0] DIGIT_THOUSANDS = 2'd3;

   // millivolts = (s * 5000 + 500) >> 10
   localparam int SHOWN_W   = 13;
   localparam int MV_PROD_W = 23;
   localparam int MV_SHIFT  = 10;
   localparam logic [SHOWN_W-1:0] MV_SCALE = 13'd5000;
   localparam logic [SHOWN_W-1:0] MV_ROUND = 13'd500;

   // x / 10^p = (x * RECIP) >> 23, exact for x below 21000
   localparam int RECIP_W     = 24;
   localparam int RECIP_SHIFT = 23;
   localparam int PROD_W      = SHOWN_W + RECIP_W;
   localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

   localparam logic [RECIP_W-1:0] RECIP_LO [DIGIT_NUM] =
      '{24'd8388608, 24'd838861, 24'd83887, 24'd8389};
   localparam logic [RECIP_W-1:0] RECIP_HI [DIGIT_NUM] =
      '{24'd838861, 24'd83887, 24'd8389, 24'd0};

   localparam logic [DIGEN_W-1:0] DIGIT_SEL [DIGIT_NUM] =
      '{4'h7, 4'hB, 4'hD, 4'hE};
   localparam logic [DIGEN_W-1:0] DIGEN_OFF = 4'hF;

   localparam logic [SEG_W-1:0] SEG_DP  = 8'h80;
   localparam logic [SEG_W-1:0] SEG_OFF = 8'h00;

   function automatic logic [SEG_W-1:0] seg_font(input logic [DIGIT_W-1:0] digit);
      logic [SEG_W-1:0] seg;
      case (digit)
         4'd0: seg = 8'h3f;
         4'd1: seg = 8'h06;
         4'd2: seg = 8'h5b;
         4'd3: seg = 8'h4f;
         4'd4: seg = 8'h66;
         4'd5: seg = 8'h6d;
         4'd6: seg = 8'h7c;
         4'd7: seg = 8'h07;
         4'd8: seg = 8'h7f;
         4'd9: seg = 8'h67;
         default: seg = SEG_OFF;
      endcase
      return seg;
   endfunction

endpackage

/* design/adc_meter_display_driver.sv */
// ADC meter display driver: bar graph, PWM compares and multiplexed digit scan.
// Depends on admdd_pkg and adc_meter_display_driver_macros.svh.
// Pipeline: a req transfer is registered into stage 1 (millivolt multiply), then digit
//   extraction is registered into the output register that drives rsp_tvalid.
// Throughput: one item per cycle; req_tready drops only while both stages are full and
//   rsp_tready is low.
// Reset (synchronous, active high): held sample, digit position, display_mode and
//   both stage valids clear.
`include "adc_meter_display_driver_macros.svh"

module adc_meter_display_driver import admdd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // sample[9:0], zero [15:10]
   input  logic                  req_tuser,   // mode[0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // bar_leds[7:0], pwm_falling[17:8],
                                              // pwm_rising[27:18], digit_enable[31:28],
                                              // segments[39:32]
   output logic                  rsp_tuser,   // scan_update[0]
   input  logic                  csr_we,
   input  logic                  csr_wdata
);

   logic                  display_mode_ff;
   logic [SAMPLE_W-1:0]   held_sample_ff, held_sample_in;
   logic [POS_W-1:0]      digit_pos_ff, digit_pos_in;

   logic                  s1_valid_ff, s1_tick_ff, s1_dp_ff;
   logic [SAMPLE_W-1:0]   s1_held_ff;
   logic [SHOWN_W-1:0]    s1_shown_ff;
   logic [POS_W-1:0]      s1_pos_ff;

   logic                  rsp_valid_ff, rsp_user_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  req_xfer, is_tick, out_open, s1_move;
   logic [MV_PROD_W-1:0]  mv_prod;
   logic [SHOWN_W-1:0]    shown;

   logic [PROD_W-1:0]     lo_prod, hi_prod;
   logic [QUOT_W-1:0]     lo_quot, hi_quot, digit_wide;
   logic [DIGIT_W-1:0]    digit;
   logic [SAMPLE_W:0]     held_p1;
   logic [BAR_W:0]        bar_wide;
   logic [BAR_W-1:0]      bar_leds;
   logic [SAMPLE_W-1:0]   pwm_falling;
   logic [DIGEN_W-1:0]    digit_enable;
   logic [SEG_W-1:0]      segments;

   assign out_open   = !rsp_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_open;
   assign req_tready = !s1_valid_ff || out_open;
   assign req_xfer   = req_tvalid && req_tready;
   assign is_tick    = (req_tuser == MODE_TICK);

   // stage 1: state update and millivolt conversion
   assign held_sample_in = (req_xfer && !is_tick) ? req_tdata[SAMPLE_W-1:0] : held_sample_ff;
   assign digit_pos_in   = (req_xfer && is_tick) ? digit_pos_ff + POS_W'(1) : digit_pos_ff;

   assign mv_prod = MV_PROD_W'(held_sample_ff) * MV_PROD_W'(MV_SCALE) + MV_PROD_W'(MV_ROUND);
   assign shown   = display_mode_ff ? mv_prod[MV_PROD_W-1:MV_SHIFT] : SHOWN_W'(held_sample_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         display_mode_ff <= 1'b0;
         held_sample_ff  <= '0;
         digit_pos_ff    <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            display_mode_ff <= csr_wdata;
         end
         held_sample_ff <= held_sample_in;
         digit_pos_ff   <= digit_pos_in;
         if (req_xfer) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_tick_ff  <= is_tick;
         s1_held_ff  <= held_sample_in;
         s1_shown_ff <= shown;
         s1_pos_ff   <= digit_pos_ff;
         s1_dp_ff    <= display_mode_ff && (digit_pos_ff == DIGIT_THOUSANDS);
      end
   end

   // stage 2: digit = floor(x / 10^p) - 10 * floor(x / 10^(p+1))
   assign lo_prod    = PROD_W'(s1_shown_ff) * PROD_W'(RECIP_LO[s1_pos_ff]);
   assign hi_prod    = PROD_W'(s1_shown_ff) * PROD_W'(RECIP_HI[s1_pos_ff]);
   assign lo_quot    = lo_prod[PROD_W-1:RECIP_SHIFT];
   assign hi_quot    = hi_prod[PROD_W-1:RECIP_SHIFT];
   assign digit_wide = lo_quot - ((hi_quot << 3) + (hi_quot << 1));
   assign digit      = digit_wide[DIGIT_W-1:0];

   assign held_p1     = (SAMPLE_W+1)'(s1_held_ff) + (SAMPLE_W+1)'(1);
   assign bar_wide    = ((BAR_W+1)'(1) << held_p1[SAMPLE_W:7]) - (BAR_W+1)'(1);
   assign bar_leds    = bar_wide[BAR_W-1:0];
   assign pwm_falling = ~s1_held_ff;

   always_comb begin
      if (s1_tick_ff) begin
         digit_enable = DIGIT_SEL[s1_pos_ff];
         segments     = seg_font(digit) | (s1_dp_ff ? SEG_DP : SEG_OFF);
      end else begin
         digit_enable = DIGEN_OFF;
         segments     = SEG_OFF;
      end
   end

   assign rsp_data_in = {segments, digit_enable, s1_held_ff, pwm_falling, bar_leds};

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= s1_tick_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `AMD_ASSERT_NORST(a_reset_empties, clock, reset |=> !rsp_tvalid && !s1_valid_ff, "output valid after reset")
   `AMD_ASSERT(a_sample_held, clock, reset, (req_xfer && !is_tick) |=> held_sample_ff == $past(req_tdata[SAMPLE_W-1:0]), "sample not held")
   `AMD_ASSERT(a_pos_advance, clock, reset, (req_xfer && is_tick) |=> digit_pos_ff == $past(digit_pos_ff) + POS_W'(1), "digit position did not advance")
   `AMD_ASSERT(a_pos_hold, clock, reset, !(req_xfer && is_tick) |=> $stable(digit_pos_ff), "digit position moved without tick")
   `AMD_ASSERT(a_full_stall, clock, reset, (s1_valid_ff && rsp_tvalid && !rsp_tready) |-> !req_tready, "transfer accepted with pipeline full")

endmodule

/* verif/adc_meter_display_driver_test.sv */
// Self-checking testbench for adc_meter_display_driver: directed and random samples and
// scan ticks, random idling on both stream sides, a long receiver stall, in-line prediction.
// Depends on admdd_pkg and the adc_meter_display_driver RTL.
`timescale 1ns / 100ps

module adc_meter_display_driver_test;
   import admdd_pkg::*;

   localparam int PIPE_LATENCY = 2;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int HOLD_CYCLES  = 200;

   localparam logic [7:0] FONT [10] =
      '{8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7c, 8'h07, 8'h7f, 8'h67};
   localparam logic [3:0] SELECT [4] = '{4'h7, 4'hB, 4'hD, 4'hE};
   localparam logic [3:0] NO_DIGIT = 4'hF;
   localparam logic [7:0] DOT      = 8'h80;

   typedef struct packed {
      logic [7:0] bar;
      logic [9:0] falling;
      logic [9:0] rising;
      logic       scan;
      logic [3:0] digen;
      logic [7:0] seg;
   } display_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // sample[9:0], zero [15:10]
   logic                  req_tuser;   // mode[0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // bar[7:0], falling[17:8], rising[27:18],
                                       // digit_enable[31:28], segments[39:32]
   logic                  rsp_tuser;   // scan_update[0]
   logic                  csr_we;
   logic                  csr_wdata;

   // predictor state
   logic [9:0] held_value;
   logic [1:0] scan_pos;
   logic       show_mv;

   display_type expected_display [$];
   int       error_count = 0;
   int       send_idle_pct = 0;
   int       recv_idle_pct = 0;
   logic     hold_start = 1'b0;
   int       hold_left = 0;
   int       cycle_count = 0;

   adc_meter_display_driver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic display_type display_for_item(input logic kind, input logic [9:0] value);
      display_type d;
      int shown;
      int digit;
      int lit;
      if (kind == MODE_SAMPLE) begin
         held_value = value;
         d.scan  = 1'b0;
         d.digen = NO_DIGIT;
         d.seg   = 8'h00;
      end else begin
         shown = show_mv ? (int'(held_value) * 5000 + 500) >> 10 : int'(held_value);
         case (scan_pos)
            2'd0:    digit = shown % 10;
            2'd1:    digit = (shown / 10) % 10;
            2'd2:    digit = (shown / 100) % 10;
            default: digit = (shown / 1000) % 10;
         endcase
         d.seg = FONT[digit];
         if (scan_pos == DIGIT_THOUSANDS && show_mv)
            d.seg = d.seg | DOT;
         d.digen  = SELECT[scan_pos];
         d.scan   = 1'b1;
         scan_pos = scan_pos + 2'd1;
      end
      lit       = (int'(held_value) + 1) >> 7;
      d.bar     = 8'((1 << lit) - 1);
      d.falling = 10'd1023 - held_value;
      d.rising  = held_value;
      return d;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
      error_count++;
   endtask

   // result checker and receiver idling
   always @(posedge clock) begin
      display_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_display.size() == 0) begin
            report_mismatch("unexpected transfer", int'(rsp_tdata[31:0]), 0);
         end else begin
            want = expected_display.pop_front();
            if (rsp_tdata[7:0] !== want.bar)
               report_mismatch("bar_leds", int'(rsp_tdata[7:0]), int'(want.bar));
            if (rsp_tdata[17:8] !== want.falling)
               report_mismatch("pwm_falling", int'(rsp_tdata[17:8]), int'(want.falling));
            if (rsp_tdata[27:18] !== want.rising)
               report_mismatch("pwm_rising", int'(rsp_tdata[27:18]), int'(want.rising));
            if (rsp_tuser !== want.scan)
               report_mismatch("scan_update", int'(rsp_tuser), int'(want.scan));
            if (rsp_tdata[31:28] !== want.digen)
               report_mismatch("digit_enable", int'(rsp_tdata[31:28]), int'(want.digen));
            if (rsp_tdata[39:32] !== want.seg)
               report_mismatch("segments", int'(rsp_tdata[39:32]), int'(want.seg));
         end
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_start) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_item(input logic kind, input logic [9:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'b0, value};
      do @(posedge clock); while (!req_tready);
      expected_display.push_back(display_for_item(kind, value));
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_item(MODE_TICK, 10'($urandom));
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (expected_display.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY) @(posedge clock);
   endtask

   task automatic set_display_mode(input logic mv);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= mv;
      @(posedge clock);
      csr_we    <= 1'b0;
      show_mv = mv;
   endtask

   function automatic logic [9:0] pick_sample;
      case ($urandom_range(7))
         0:       return 10'd0;
         1:       return 10'd1023;
         2:       return 10'(127 + 128 * $urandom_range(6) + $urandom_range(1));
         default: return 10'($urandom_range(1023));
      endcase
   endfunction

   task automatic test_directed_raw;
      set_display_mode(1'b0);
      send_item(MODE_SAMPLE, 10'd0);
      send_ticks(1);
      send_item(MODE_SAMPLE, 10'd126);
      send_item(MODE_SAMPLE, 10'd127);
      send_item(MODE_SAMPLE, 10'd1022);
      send_item(MODE_SAMPLE, 10'd1023);
      send_ticks(4);
      send_item(MODE_SAMPLE, 10'd999);
      send_ticks(4);
   endtask

   task automatic test_directed_millivolts;
      set_display_mode(1'b1);
      send_ticks(4);
      send_item(MODE_SAMPLE, 10'd1);
      send_ticks(4);
      send_item(MODE_SAMPLE, 10'd0);
      send_ticks(2);
   endtask

   task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
      send_idle_pct <= send_pct;
      recv_idle_pct <= recv_pct;
      for (int chunk = 0; chunk < 4; chunk++) begin
         set_display_mode(chunk[0] ^ 1'($urandom_range(1)));
         for (int i = 0; i < count / 4; i++) begin
            if ($urandom_range(99) < 65)
               send_ticks(1);
            else
               send_item(MODE_SAMPLE, pick_sample());
         end
      end
   endtask

   task automatic test_receiver_backpressure;
      drain();
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      hold_start    <= 1'b1;
      @(posedge clock);
      hold_start    <= 1'b0;
      for (int i = 0; i < 40; i++) begin
         if (i % 3 == 0)
            send_item(MODE_SAMPLE, pick_sample());
         else
            send_ticks(1);
      end
      drain();
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= MODE_SAMPLE;
      csr_we     <= 1'b0;
      csr_wdata  <= 1'b0;
      held_value = '0;
      scan_pos   = '0;
      show_mv    = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_raw();
      test_directed_millivolts();
      test_random_traffic(480, 31, 58);
      test_random_traffic(480, 58, 31);
      test_random_traffic(480, 0, 0);
      test_receiver_backpressure();

      drain();
      repeat (PIPE_LATENCY + 4) @(posedge clock);
      if (expected_display.size() != 0)
         report_mismatch("results missing", expected_display.size(), 0);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
